### rtl/pcik_pkg.sv
// ----------------------------------------------------------------------------
// Planar chain IK solver package
// Shared sizes, constants, codes, payload types and helper functions.
// ----------------------------------------------------------------------------
package pcik_pkg;

  // Chain size and CORDIC depth.
  localparam int NUM_JOINTS   = 8;
  localparam int CORDIC_ITERS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int JW           = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int ITER_W       = $clog2(ATAN_LEN);

  // CORDIC datapath widths: x/y carry vector coordinates times 256 plus gain growth.
  localparam int XW = 36;
  localparam int ZW = 33;

  localparam logic signed [XW-1:0] KGAIN_Q30   = 36'sd652032874;
  localparam logic signed [31:0]   ONE_Q30     = 32'sd1073741824;
  localparam logic signed [31:0]   RAD2BAU_Q16 = 32'sd683565276;

  // Arctangent of 2^-i as a fraction of a full turn times 2^32.
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Smallest nonzero CCD step in angle units.
  localparam logic signed [17:0] MIN_STEP = 18'sd2;

  // Register reset values.
  localparam int RST_BASE_X  = 300;
  localparam int RST_BASE_Y  = 300;
  localparam int RST_SEG_LEN = 30;
  localparam int RST_LIMIT   = 8192;
  localparam int RST_GAIN    = 1311;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IK_ENABLE  = 3'd0,
    CFG_IK_MODE    = 3'd1,
    CFG_BASE_X     = 3'd2,
    CFG_BASE_Y     = 3'd3,
    CFG_SEG_LEN    = 3'd4,
    CFG_ANGLE_LIM  = 3'd5,
    CFG_DOT_GAIN   = 3'd6
  } cfg_idx_e;

  // Command and mode codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POSE = 1'b1;
  localparam logic MODE_DOT = 1'b0;
  localparam logic MODE_CCD = 1'b1;

  typedef enum logic {
    OP_SINCOS = 1'b0,
    OP_ATAN2  = 1'b1
  } cordic_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RF_INIT,
    ST_RF_START,
    ST_RF_WAIT,
    ST_RF_MX,
    ST_RF_MY,
    ST_RF_WR,
    ST_CCD_S,
    ST_CCD_A,
    ST_CCD_AW,
    ST_CCD_B,
    ST_CCD_BW,
    ST_CCD_U,
    ST_DOT_S,
    ST_DOT_AW,
    ST_DOT_SW,
    ST_DOT_M1,
    ST_DOT_M2,
    ST_DOT_M3,
    ST_DOT_M4,
    ST_OUT
  } ik_state_e;

  typedef struct packed {
    logic              command;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic              select_valid;
    logic [4:0]        end_joint;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         joint_index;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic signed [15:0] joint_angle_out;
    logic               last;
  } out_item_t;

  // Request to and response from the shared CORDIC unit.
  typedef struct packed {
    logic               start;
    cordic_op_e         op;
    logic [15:0]        angle;
    logic signed [24:0] vx;
    logic signed [24:0] vy;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_val;
    logic signed [31:0] sin_val;
    logic [15:0]        bau;
  } cordic_rsp_t;

  // Saturate to the 24-bit Q15.8 range.
  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -48'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Straight chain end x for the reset registers.
  function automatic logic signed [23:0] reset_end_x(input int i);
    return 24'((RST_BASE_X + RST_SEG_LEN * (i + 2)) * 256);
  endfunction

  // Signed reading of an atan2 result; an exact half turn stays positive.
  function automatic logic signed [17:0] bau_signed(input logic [15:0] b);
    logic signed [17:0] r;
    r = $signed({2'b00, b});
    if (b > 16'd32768) begin
      r = r - 18'sd65536;
    end
    return r;
  endfunction

endpackage

### rtl/pcik_cordic.sv
// ----------------------------------------------------------------------------
// Shared CORDIC unit
// One micro-rotation per cycle; computes sine/cosine of an angle or the
// atan2 of a vector, with exact results for right angles and zero vectors.
// ----------------------------------------------------------------------------
module pcik_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcik_pkg::cordic_req_t req_i,
  output pcik_pkg::cordic_rsp_t rsp_o
);
  import pcik_pkg::*;

  logic                 busy_q, done_q, flip_q;
  cordic_op_e           op_q;
  logic [ITER_W-1:0]    iter_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, xs, ys, x0, y0, vx_ext, vy_ext;
  logic signed [ZW-1:0] z_q, z_d, z0, atan_v;
  logic signed [31:0]   cos_q, sin_q;
  logic [15:0]          bau_q, sc_ang;
  logic [31:0]          z_fin;
  logic [1:0]           quad;
  logic                 sigma, sc_exact, sc_flip, vec_zero, vec_neg, last_iter;

  // Start-up values for both operations.
  always_comb begin
    quad     = req_i.angle[15:14];
    sc_exact = (req_i.angle[13:0] == 14'd0);
    sc_flip  = (quad == 2'd1) || (quad == 2'd2);
    sc_ang   = {req_i.angle[15] ^ sc_flip, req_i.angle[14:0]};
    vec_zero = (req_i.vx == 25'sd0) && (req_i.vy == 25'sd0);
    vec_neg  = req_i.vx[24];
    vx_ext   = {{(XW-33){req_i.vx[24]}}, req_i.vx, 8'h00};
    vy_ext   = {{(XW-33){req_i.vy[24]}}, req_i.vy, 8'h00};
    if (req_i.op == OP_SINCOS) begin
      x0 = KGAIN_Q30;
      y0 = '0;
      z0 = {sc_ang[15], sc_ang, 16'h0000};
    end else if (vec_neg) begin
      x0 = -vx_ext;
      y0 = -vy_ext;
      z0 = 33'sh080000000;
    end else begin
      x0 = vx_ext;
      y0 = vy_ext;
      z0 = '0;
    end
  end

  // One micro-rotation; direction from the residual angle or the sign of y.
  always_comb begin
    xs        = x_q >>> iter_q;
    ys        = y_q >>> iter_q;
    atan_v    = {1'b0, ATAN_TAB[iter_q]};
    sigma     = (op_q == OP_SINCOS) ? !z_q[ZW-1] : y_q[XW-1];
    x_d       = sigma ? (x_q - ys) : (x_q + ys);
    y_d       = sigma ? (y_q + xs) : (y_q - xs);
    z_d       = sigma ? (z_q - atan_v) : (z_q + atan_v);
    z_fin     = z_d[31:0] + 32'h0000_8000;
    last_iter = (iter_q == ITER_W'(CORDIC_ITERS - 1));
  end

  // Sequencing control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_SINCOS;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q   <= req_i.op;
        iter_q <= '0;
        if ((req_i.op == OP_SINCOS) ? sc_exact : vec_zero) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (last_iter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath and held results.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      flip_q <= sc_flip;
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      if (req_i.op == OP_SINCOS && sc_exact) begin
        cos_q <= (quad == 2'd0) ? ONE_Q30 : (quad == 2'd2) ? -ONE_Q30 : 32'sd0;
        sin_q <= (quad == 2'd1) ? ONE_Q30 : (quad == 2'd3) ? -ONE_Q30 : 32'sd0;
      end
      if (req_i.op == OP_ATAN2 && vec_zero) begin
        bau_q <= 16'd0;
      end
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      if (last_iter) begin
        if (op_q == OP_SINCOS) begin
          cos_q <= flip_q ? -x_d[31:0] : x_d[31:0];
          sin_q <= flip_q ? -y_d[31:0] : y_d[31:0];
        end else begin
          bau_q <= z_fin[31:16];
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, cos_val: cos_q, sin_val: sin_q, bau: bau_q};

endmodule

### rtl/planar_chain_ik_solver_core.sv
// ----------------------------------------------------------------------------
// Planar chain IK solver core
// Holds the pose of a planar chain, runs one CCD or dot-product solver pass
// per enabled tick on a shared CORDIC unit, and reports one item per joint.
// ----------------------------------------------------------------------------
//  Channel  | Signals                             | Direction
//  ---------+-------------------------------------+----------
//  in       | in_valid_i, in_stall_o, in_item_i   | command items in
//  out      | out_valid_o, out_stall_i, out_item_o| joint items out
//  cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i    | register writes
//
// One item at a time; in_stall_o is high from acceptance until the last
// joint item is taken. Reset loads the straight chain at once; out_stall_i
// only holds the current joint item.
// ----------------------------------------------------------------------------
module planar_chain_ik_solver_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pcik_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pcik_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [pcik_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pcik_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import pcik_pkg::*;

  ik_state_e state_q, state_d;

  // Configuration registers.
  logic               en_q, mode_q;
  logic signed [15:0] base_x_q, base_y_q;
  logic [9:0]         seg_len_q;
  logic [14:0]        lim_q;
  logic [15:0]        gain_q;

  // Pose stores.
  logic [15:0]        ang_q [NUM_JOINTS];
  logic signed [23:0] ex_q  [NUM_JOINTS];
  logic signed [23:0] ey_q  [NUM_JOINTS];
  logic signed [15:0] nx_q  [NUM_JOINTS];
  logic signed [15:0] ny_q  [NUM_JOINTS];

  // Sequencer and working registers.
  logic [JW-1:0]      j_q, k_q, sel_q, rd_idx;
  logic               ret_ccd_q;
  logic signed [23:0] tx_q, ty_q, px_q, py_q;
  logic [15:0]        cum_q;
  logic signed [17:0] ra_q;
  logic signed [47:0] mul_q;
  logic signed [16:0] d14_q;
  logic signed [33:0] g_q;

  cordic_req_t cq;
  cordic_rsp_t cr;

  // Combinational helpers.
  logic [15:0]        rd_ang, cum_next, ang_dot;
  logic signed [23:0] rd_ex, rd_ey, rd_nx, rd_ny, start0_x, start0_y, pos_base, pos_new;
  logic signed [47:0] mul_d, rnd, dot_sum;
  logic signed [15:0] nrm_x, nrm_y;
  logic signed [32:0] sin_r, ncos_r;
  logic signed [24:0] dvx, dvy, avx, avy, bvx, bvy;
  logic signed [16:0] d14_d;
  logic signed [33:0] g_d;
  logic signed [65:0] prod, prod_r;
  logic signed [17:0] rb, d0, d1, d2;
  logic signed [18:0] a19, lim19, a_cl;
  logic               accept, in_sel_ok, k_last, j_zero, dv_zero;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_sel_ok = in_item_i.select_valid && ({1'b0, in_item_i.end_joint} < 6'(NUM_JOINTS));
  assign k_last    = (k_q == JW'(NUM_JOINTS - 1));
  assign j_zero    = (j_q == '0);

  // One read index for all stores, chosen by the sequencer step.
  always_comb begin
    case (state_q)
      ST_CCD_S:  rd_idx = j_q - 1'b1;
      ST_CCD_A:  rd_idx = sel_q;
      ST_CCD_U,
      ST_DOT_S,
      ST_DOT_AW,
      ST_DOT_SW,
      ST_DOT_M1,
      ST_DOT_M2,
      ST_DOT_M3,
      ST_DOT_M4: rd_idx = j_q;
      default:   rd_idx = k_q;
    endcase
    rd_ang = ang_q[rd_idx];
    rd_ex  = ex_q[rd_idx];
    rd_ey  = ey_q[rd_idx];
    rd_nx  = 24'(nx_q[rd_idx]);
    rd_ny  = 24'(ny_q[rd_idx]);
  end

  // Forward kinematics arithmetic.
  always_comb begin
    start0_x = sat24((48'(base_x_q) <<< 8) + $signed({20'd0, seg_len_q, 8'h00}));
    start0_y = sat24(48'(base_y_q) <<< 8);
    cum_next = cum_q + rd_ang;
    case (state_q)
      ST_RF_MX:  mul_d = 48'($signed({1'b0, seg_len_q})) * 48'(cr.cos_val);
      ST_RF_MY:  mul_d = 48'($signed({1'b0, seg_len_q})) * 48'(cr.sin_val);
      default:   mul_d = 48'(rd_nx) * 48'(cr.cos_val);
    endcase
    rnd      = (mul_q + 48'sd2097152) >>> 22;
    pos_base = (state_q == ST_RF_MY) ? px_q : py_q;
    pos_new  = sat24(48'(pos_base) + rnd);
    sin_r    = (33'(cr.sin_val) + 33'sd32768) >>> 16;
    ncos_r   = (-33'(cr.cos_val) + 33'sd32768) >>> 16;
    nrm_x    = sin_r[15:0];
    nrm_y    = ncos_r[15:0];
  end

  // Vector operands for the atan2 runs.
  always_comb begin
    dvx     = 25'(tx_q) - 25'(rd_ex);
    dvy     = 25'(ty_q) - 25'(rd_ey);
    dv_zero = (dvx == 25'sd0) && (dvy == 25'sd0);
    avx     = 25'(rd_ex) - 25'(px_q);
    avy     = 25'(rd_ey) - 25'(py_q);
    bvx     = 25'(tx_q) - 25'(px_q);
    bvy     = 25'(ty_q) - 25'(py_q);
  end

  // Dot-mode step: normal dot unit vector, then gain and radian scaling.
  always_comb begin
    dot_sum = mul_q + 48'(rd_ny) * 48'(cr.sin_val);
    d14_d   = 17'((dot_sum + 48'sd536870912) >>> 30);
    g_d     = 34'(d14_q) * $signed({18'd0, gain_q});
    prod    = 66'(g_q) * 66'(RAD2BAU_Q16);
    prod_r  = (prod + (66'sd1 <<< 45)) >>> 46;
    ang_dot = rd_ang - prod_r[15:0];
  end

  // CCD step: wrapped difference, minimum step, clamp.
  always_comb begin
    rb = bau_signed(cr.bau);
    d0 = rb - ra_q;
    if (d0 > 18'sd32768) begin
      d1 = d0 - 18'sd65536;
    end else if (d0 < -18'sd32768) begin
      d1 = d0 + 18'sd65536;
    end else begin
      d1 = d0;
    end
    if (d1 > 18'sd0 && d1 < MIN_STEP) begin
      d2 = MIN_STEP;
    end else if (d1 < 18'sd0 && d1 > -MIN_STEP) begin
      d2 = -MIN_STEP;
    end else begin
      d2 = d1;
    end
    a19   = 19'($signed(rd_ang)) + 19'(d2);
    lim19 = $signed({4'd0, lim_q});
    if (a19 > lim19) begin
      a_cl = lim19;
    end else if (a19 < -lim19) begin
      a_cl = -lim19;
    end else begin
      a_cl = a19;
    end
  end

  // Next state, CORDIC requests and handshake outputs.
  always_comb begin
    state_d     = state_q;
    cq          = '{start: 1'b0, op: OP_SINCOS, angle: cum_next, vx: bvx, vy: bvy};
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.command == CMD_POSE) begin
            state_d = ST_RF_INIT;
          end else if (in_sel_ok) begin
            if (!en_q) begin
              state_d = ST_RF_INIT;
            end else if (mode_q == MODE_CCD) begin
              state_d = ST_CCD_S;
            end else begin
              state_d = ST_DOT_S;
            end
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_RF_INIT:  state_d = ST_RF_START;
      ST_RF_START: begin
        cq.start = 1'b1;
        state_d  = ST_RF_WAIT;
      end
      ST_RF_WAIT:  if (cr.done) state_d = ST_RF_MX;
      ST_RF_MX:    state_d = ST_RF_MY;
      ST_RF_MY:    state_d = ST_RF_WR;
      ST_RF_WR: begin
        if (!k_last) begin
          state_d = ST_RF_START;
        end else if (ret_ccd_q && !j_zero) begin
          state_d = ST_CCD_S;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_CCD_S:    state_d = ST_CCD_A;
      ST_CCD_A: begin
        cq      = '{start: 1'b1, op: OP_ATAN2, angle: cum_next, vx: avx, vy: avy};
        state_d = ST_CCD_AW;
      end
      ST_CCD_AW:   if (cr.done) state_d = ST_CCD_B;
      ST_CCD_B: begin
        cq      = '{start: 1'b1, op: OP_ATAN2, angle: cum_next, vx: bvx, vy: bvy};
        state_d = ST_CCD_BW;
      end
      ST_CCD_BW:   if (cr.done) state_d = ST_CCD_U;
      ST_CCD_U:    state_d = ST_RF_INIT;
      ST_DOT_S: begin
        if (dv_zero) begin
          state_d = j_zero ? ST_RF_INIT : ST_DOT_S;
        end else begin
          cq      = '{start: 1'b1, op: OP_ATAN2, angle: cum_next, vx: dvx, vy: dvy};
          state_d = ST_DOT_AW;
        end
      end
      ST_DOT_AW: begin
        if (cr.done) begin
          cq      = '{start: 1'b1, op: OP_SINCOS, angle: cr.bau, vx: dvx, vy: dvy};
          state_d = ST_DOT_SW;
        end
      end
      ST_DOT_SW:   if (cr.done) state_d = ST_DOT_M1;
      ST_DOT_M1:   state_d = ST_DOT_M2;
      ST_DOT_M2:   state_d = ST_DOT_M3;
      ST_DOT_M3:   state_d = ST_DOT_M4;
      ST_DOT_M4:   state_d = j_zero ? ST_RF_INIT : ST_DOT_S;
      ST_OUT: begin
        if (!out_stall_i && k_last) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state, configuration and pose stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b1;
      mode_q    <= MODE_CCD;
      base_x_q  <= 16'(RST_BASE_X);
      base_y_q  <= 16'(RST_BASE_Y);
      seg_len_q <= 10'(RST_SEG_LEN);
      lim_q     <= 15'(RST_LIMIT);
      gain_q    <= 16'(RST_GAIN);
      j_q       <= '0;
      k_q       <= '0;
      sel_q     <= '0;
      ret_ccd_q <= 1'b0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        ang_q[i] <= 16'd0;
        ex_q[i]  <= reset_end_x(i);
        ey_q[i]  <= 24'(RST_BASE_Y * 256);
        nx_q[i]  <= 16'sd0;
        ny_q[i]  <= -16'sd16384;
      end
    end else begin
      // Register writes must arrive only while the block is idle; the block itself does not enforce it.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IK_ENABLE: en_q      <= cfg_wdata_i[0];
          CFG_IK_MODE:   mode_q    <= cfg_wdata_i[0];
          CFG_BASE_X:    base_x_q  <= cfg_wdata_i;
          CFG_BASE_Y:    base_y_q  <= cfg_wdata_i;
          CFG_SEG_LEN:   seg_len_q <= cfg_wdata_i[9:0];
          CFG_ANGLE_LIM: lim_q     <= cfg_wdata_i[14:0];
          CFG_DOT_GAIN:  gain_q    <= cfg_wdata_i;
          default:       ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (accept) begin
            sel_q     <= in_item_i.end_joint[JW-1:0];
            j_q       <= in_item_i.end_joint[JW-1:0];
            ret_ccd_q <= 1'b0;
            if (in_item_i.command == CMD_POSE) begin
              for (int i = 0; i < NUM_JOINTS; i++) begin
                ang_q[i] <= 16'd0;
              end
            end
          end
        end
        ST_RF_INIT: k_q <= '0;
        ST_RF_MY:   ex_q[k_q] <= pos_new;
        ST_RF_WR: begin
          ey_q[k_q] <= pos_new;
          nx_q[k_q] <= nrm_x;
          ny_q[k_q] <= nrm_y;
          if (k_last) begin
            k_q <= '0;
            if (ret_ccd_q && !j_zero) begin
              j_q <= j_q - 1'b1;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_CCD_U: begin
          ang_q[j_q] <= a_cl[15:0];
          ret_ccd_q  <= 1'b1;
        end
        ST_DOT_S: begin
          if (dv_zero && !j_zero) begin
            j_q <= j_q - 1'b1;
          end
        end
        ST_DOT_M4: begin
          ang_q[j_q] <= ang_dot;
          if (!j_zero) begin
            j_q <= j_q - 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall_i && !k_last) begin
            k_q <= k_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        tx_q <= 24'(in_item_i.target_x) <<< 8;
        ty_q <= 24'(in_item_i.target_y) <<< 8;
      end
      ST_RF_INIT: begin
        px_q  <= start0_x;
        py_q  <= start0_y;
        cum_q <= 16'd0;
      end
      ST_RF_START: cum_q <= cum_next;
      ST_RF_MX:    mul_q <= mul_d;
      ST_RF_MY: begin
        px_q  <= pos_new;
        mul_q <= mul_d;
      end
      ST_RF_WR:    py_q <= pos_new;
      ST_CCD_S: begin
        px_q <= j_zero ? start0_x : rd_ex;
        py_q <= j_zero ? start0_y : rd_ey;
      end
      ST_CCD_AW:   if (cr.done) ra_q <= bau_signed(cr.bau);
      ST_DOT_M1:   mul_q <= mul_d;
      ST_DOT_M2:   d14_q <= d14_d;
      ST_DOT_M3:   g_q <= g_d;
      default: ;
    endcase
  end

  pcik_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cq),
    .rsp_o  (cr)
  );

  // Result item straight from the stores at the output index.
  assign out_item_o = '{
    joint_index:     5'(k_q),
    end_x:           rd_ex,
    end_y:           rd_ey,
    joint_angle_out: rd_ang,
    last:            k_last
  };

endmodule

### rtl/pcik_checker.sv
// ----------------------------------------------------------------------------
// Planar chain IK solver port checker
// Watches the ports of the core for input busy handling and the order and hold of the per-joint items.
// ----------------------------------------------------------------------------
module pcik_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input pcik_pkg::in_item_t              in_item_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input pcik_pkg::out_item_t             out_item_o,
  input logic                            cfg_we_i,
  input logic [pcik_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [pcik_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pcik_pkg::*;

  // No new item is taken while results are being reported.
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready while results pending");

  // An accepted item keeps the block busy.
  a_busy_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block idle right after accepting an item");

  // Joint items follow in index order without gaps.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_item_o.last) |=>
      (out_valid_o && (out_item_o.joint_index == $past(out_item_o.joint_index) + 5'd1)))
    else $error("joint items out of order");

  // The final joint item ends the burst.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_item_o.last) |=> !out_valid_o)
    else $error("items continue after the last joint");

  // A stalled item holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled item changed");

endmodule

bind planar_chain_ik_solver_core pcik_checker u_pcik_checker (.*);
